FILE: design/bbfra_pkg.sv
// Shared types, register indexes and reset constants for the byte budget retention block.
package bbfra_pkg;

    // Default entry count of the rolling store
    localparam int DEPTH_DEFAULT = 1024;

    // Input queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QFILL_W     = 2;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int AMOUNT_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM_UP    = 2'd2;

    localparam logic [AMOUNT_W-1:0] CAPACITY_RESET   = 24'd535000;
    localparam logic [TIME_W-1:0]   START_TIME_RESET = 32'd0;
    localparam logic [TIME_W-1:0]   WARM_UP_RESET    = 32'd86400;

    typedef struct packed {
        logic [TIME_W-1:0]   sample_time;
        logic [AMOUNT_W-1:0] sample_amount;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0] oldest_age;
        logic              age_valid;
        logic              store_overflow;
    } t_out;

    // Sample after classification by the front
    typedef struct packed {
        logic [TIME_W-1:0]   sample_time;
        logic [AMOUNT_W-1:0] sample_amount;
        logic                past_warm;
    } t_work;

endpackage

FILE: design/bbfra_front.sv
// Front: accepts samples, classifies them against the warm-up window and queues them.
module bbfra_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  bbfra_pkg::t_in                      i_data,
    output logic                                o_stall,
    input  logic [bbfra_pkg::TIME_W-1:0]        i_start_time,
    input  logic [bbfra_pkg::TIME_W-1:0]        i_warm_up,
    output logic                                o_work_valid,
    output bbfra_pkg::t_work                    o_work,
    input  logic                                i_work_pop
);

    bbfra_pkg::t_work                  r_slot [bbfra_pkg::QUEUE_DEPTH];
    logic [bbfra_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [bbfra_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [bbfra_pkg::QFILL_W-1:0]     r_fill;
    logic                              w_push;
    logic [bbfra_pkg::TIME_W:0]        w_warm_end;
    bbfra_pkg::t_work                  w_new;

    assign o_stall      = (r_fill == bbfra_pkg::QFILL_W'(bbfra_pkg::QUEUE_DEPTH));
    assign o_work_valid = (r_fill != '0);
    assign o_work       = r_slot[r_rd_ptr];
    assign w_push       = i_valid && !o_stall;

    // Classify: age is reportable only once the sample is past start plus warm-up
    assign w_warm_end = {1'b0, i_start_time} + {1'b0, i_warm_up};
    always_comb begin
        w_new.sample_time   = i_data.sample_time;
        w_new.sample_amount = i_data.sample_amount;
        w_new.past_warm     = ({1'b0, i_data.sample_time} > w_warm_end);
    end

    // Hold queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_work_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !i_work_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!w_push && i_work_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Store the classified sample
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_new;
        end
    end

endmodule

FILE: design/bbfra_back.sv
// Back: FIFO store of entries, eviction, budget trim and head walk, result build.
module bbfra_back #(
    parameter int DEPTH = bbfra_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_work_valid,
    input  bbfra_pkg::t_work                    i_work,
    output logic                                o_work_pop,
    input  logic [bbfra_pkg::AMOUNT_W-1:0]      i_capacity,
    output logic                                o_res_valid,
    output bbfra_pkg::t_out                     o_res,
    input  logic                                i_res_take,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TW    = bbfra_pkg::TIME_W;
    localparam int AW    = bbfra_pkg::AMOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_APPEND,
        S_WALK,
        S_EMIT
    } t_state;

    // Entry store
    logic [TW-1:0] r_mem_time [DEPTH];
    logic [AW-1:0] r_mem_rem  [DEPTH];
    logic [TW-1:0] r_rd_time;
    logic [AW-1:0] r_rd_rem;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_total, n_total;
    logic [AW:0]       r_excess, n_excess;
    bbfra_pkg::t_work  r_item, n_item;
    logic              r_ovf, n_ovf;
    bbfra_pkg::t_out   r_res, n_res;

    logic              w_we;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [TW-1:0]     w_wr_time;
    logic [AW-1:0]     w_wr_rem;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [AW:0]       w_sum;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        f_next = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;
    assign o_count     = r_count;
    assign w_sum       = {1'b0, r_total} + {1'b0, r_item.sample_amount};

    // Sequence one sample: evict if full, append, trim and drop from the head, report
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_total    = r_total;
        n_excess   = r_excess;
        n_item     = r_item;
        n_ovf      = r_ovf;
        n_res      = r_res;
        o_work_pop = 1'b0;
        w_we       = 1'b0;
        w_wr_addr  = r_tail;
        w_wr_time  = r_item.sample_time;
        w_wr_rem   = r_item.sample_amount;
        w_rd_addr  = r_head;
        case (r_state)
            S_IDLE: begin
                if (i_work_valid) begin
                    o_work_pop = 1'b1;
                    n_item     = i_work;
                    n_ovf      = 1'b0;
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_state = S_EVICT;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_EVICT: begin
                // Drop the head entry and its amount
                n_total = r_total - r_rd_rem;
                n_head  = f_next(r_head);
                n_count = r_count - 1'b1;
                n_ovf   = 1'b1;
                n_state = S_APPEND;
            end
            S_APPEND: begin
                w_we    = 1'b1;
                n_tail  = f_next(r_tail);
                n_count = r_count + 1'b1;
                if (w_sum >= {1'b0, i_capacity}) begin
                    n_excess = w_sum - {1'b0, i_capacity};
                    n_total  = i_capacity;
                end else begin
                    n_excess = '0;
                    n_total  = w_sum[AW-1:0];
                end
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_count == '0) begin
                    n_res.oldest_age     = '0;
                    n_res.age_valid      = 1'b0;
                    n_res.store_overflow = r_ovf;
                    n_state              = S_EMIT;
                end else if ({1'b0, r_rd_rem} <= r_excess) begin
                    // Entry trims to zero or is already empty: pop it
                    n_excess  = r_excess - {1'b0, r_rd_rem};
                    n_head    = f_next(r_head);
                    n_count   = r_count - 1'b1;
                    w_rd_addr = f_next(r_head);
                end else begin
                    // Cut the head entry partly and report its age
                    w_we                 = 1'b1;
                    w_wr_addr            = r_head;
                    w_wr_time            = r_rd_time;
                    w_wr_rem             = r_rd_rem - r_excess[AW-1:0];
                    n_res.oldest_age     = r_item.sample_time - r_rd_time;
                    n_res.age_valid      = r_item.past_warm;
                    n_res.store_overflow = r_ovf;
                    n_state              = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, pointers and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_total <= n_total;
        end
        r_excess <= n_excess;
        r_item   <= n_item;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
    end

    // Entry memory: one write, one registered read with write-through forward
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_time[w_wr_addr] <= w_wr_time;
            r_mem_rem[w_wr_addr]  <= w_wr_rem;
        end
        if (w_we && (w_wr_addr == w_rd_addr)) begin
            r_rd_time <= w_wr_time;
            r_rd_rem  <= w_wr_rem;
        end else begin
            r_rd_time <= r_mem_time[w_rd_addr];
            r_rd_rem  <= r_mem_rem[w_rd_addr];
        end
    end

endmodule

FILE: design/byte_budget_fifo_retention_age_core.sv
// Top level: configuration registers, front and back, and the result register.
//
// Usage: samples (time, amount) arrive on i_valid/i_data and are taken when o_stall
// is low; a two-entry queue lets the sender go on while the store works. Each sample
// gives exactly one result on o_valid/o_data, in order: the age of the oldest kept
// entry, whether it is past the warm-up window, and whether the store was full so
// the oldest entry was evicted.
// Timing: the store engine works on one sample at a time; it evicts the head when
// the store is full, appends the sample, trims and drops from the head, then emits
// the result. The engine walks the head one entry per cycle through a single read
// port of the entry memory; each entry is dropped once. The next sample waits in
// the input queue until the result of the last one is taken.
// Reset clears the queue, the store pointers, the retained total and the result
// valid flag, and loads the register defaults; the entry memory is not cleared.
// When i_stall is high the result holds in its register and the engine waits to
// emit; the input queue then fills and raises o_stall.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is high,
// only while no sample is in flight.
module byte_budget_fifo_retention_age_core #(
    parameter int DEPTH = bbfra_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  bbfra_pkg::t_in                      i_data,
    output logic                                o_stall,
    output logic                                o_valid,
    output bbfra_pkg::t_out                     o_data,
    input  logic                                i_stall,
    input  logic                                i_cfg_we,
    input  logic [bbfra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbfra_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [bbfra_pkg::AMOUNT_W-1:0] r_capacity;
    logic [bbfra_pkg::TIME_W-1:0]   r_start_time;
    logic [bbfra_pkg::TIME_W-1:0]   r_warm_up;
    logic                           r_out_valid;
    bbfra_pkg::t_out                r_out;

    logic                           w_work_valid;
    bbfra_pkg::t_work               w_work;
    logic                           w_work_pop;
    logic                           w_res_valid;
    bbfra_pkg::t_out                w_res;
    logic                           w_res_take;
    logic [CNT_W-1:0]               w_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= bbfra_pkg::CAPACITY_RESET;
            r_start_time <= bbfra_pkg::START_TIME_RESET;
            r_warm_up    <= bbfra_pkg::WARM_UP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bbfra_pkg::CFG_CAPACITY: begin
                    r_capacity <= i_cfg_data[bbfra_pkg::AMOUNT_W-1:0];
                end
                bbfra_pkg::CFG_START_TIME: begin
                    r_start_time <= i_cfg_data;
                end
                bbfra_pkg::CFG_WARM_UP: begin
                    r_warm_up <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    bbfra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_stall      (o_stall),
        .i_start_time (r_start_time),
        .i_warm_up    (r_warm_up),
        .o_work_valid (w_work_valid),
        .o_work       (w_work),
        .i_work_pop   (w_work_pop)
    );

    bbfra_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .i_capacity   (r_capacity),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_take   (w_res_take),
        .o_count      (w_count)
    );

    // Result register: load when empty or being drained
    assign w_res_take = w_res_valid && (!r_out_valid || !i_stall);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

`ifndef ASSERT_OFF
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall active right after reset");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work_pop |-> w_work_valid)
        else $error("back took a sample from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(DEPTH))
        else $error("store entry count above depth");
`endif

endmodule

FILE: sim/tb_byte_budget_fifo_retention_age_core.sv
// Self-checking testbench for the byte budget retention age core: directed table, then random phases.
module tb_byte_budget_fifo_retention_age_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH  = bbfra_pkg::DEPTH_DEFAULT;
    localparam int CFG_SETTLE   = 16;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [bbfra_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_CHECKED
    } t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        logic [bbfra_pkg::CFG_IDX_W-1:0]    idx;
        logic [bbfra_pkg::CFG_DATA_W-1:0]   val;
        bbfra_pkg::t_in                     smp;
        bbfra_pkg::t_out                    want;
    } t_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    bbfra_pkg::t_in                     i_data;
    logic                               o_stall;
    logic                               o_valid;
    bbfra_pkg::t_out                    o_data;
    logic                               i_stall;
    logic                               i_cfg_we;
    logic [bbfra_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [bbfra_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    // Shadow of the rolling store
    logic [bbfra_pkg::TIME_W-1:0]       kept_time [STORE_DEPTH];
    logic [bbfra_pkg::AMOUNT_W-1:0]     kept_mb   [STORE_DEPTH];
    int unsigned                        head_slot;
    int unsigned                        tail_slot;
    int unsigned                        kept_entries;
    int unsigned                        kept_total;
    logic [bbfra_pkg::AMOUNT_W-1:0]     cap_mb;
    logic [bbfra_pkg::TIME_W-1:0]       start_s;
    logic [bbfra_pkg::TIME_W-1:0]       warm_s;

    bbfra_pkg::t_out                    age_expected [$];
    t_row                               directed_rows [$];
    int                                 errors;
    bit                                 bursts_on;
    int                                 stall_left;
    logic [bbfra_pkg::TIME_W-1:0]       now_s;

    byte_budget_fifo_retention_age_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Drop the head entry and take its amount out of the total
    function automatic void drop_head();
        kept_total   = kept_total - kept_mb[head_slot];
        head_slot    = (head_slot + 1) % STORE_DEPTH;
        kept_entries = kept_entries - 1;
    endfunction

    // Evict if full, append one sample, trim to the budget and report the oldest age
    function automatic bbfra_pkg::t_out predict_age(input bbfra_pkg::t_in smp);
        bbfra_pkg::t_out r;
        int unsigned    sum;
        int unsigned    excess;
        int unsigned    idx;
        int unsigned    n;
        logic [32:0]    warm_end;
        r = '0;
        if (kept_entries >= STORE_DEPTH) begin
            drop_head();
            r.store_overflow = 1'b1;
        end
        kept_time[tail_slot] = smp.sample_time;
        kept_mb[tail_slot]   = smp.sample_amount;
        tail_slot            = (tail_slot + 1) % STORE_DEPTH;
        kept_entries         = kept_entries + 1;
        sum = kept_total + smp.sample_amount;
        // Cut the excess from the oldest entries
        if (sum >= cap_mb) begin
            excess = sum - cap_mb;
            idx    = head_slot;
            for (n = 0; n < kept_entries; n++) begin
                if (kept_mb[idx] != '0) begin
                    if (kept_mb[idx] <= excess) begin
                        excess      = excess - kept_mb[idx];
                        kept_mb[idx] = '0;
                    end else begin
                        kept_mb[idx] = kept_mb[idx] - excess;
                        break;
                    end
                end
                idx = (idx + 1) % STORE_DEPTH;
            end
            sum = cap_mb;
        end
        kept_total = sum;
        while (kept_entries > 0 && kept_mb[head_slot] == '0)
            drop_head();
        if (kept_entries > 0) begin
            r.oldest_age = smp.sample_time - kept_time[head_slot];
            warm_end     = {1'b0, start_s} + {1'b0, warm_s};
            r.age_valid  = ({1'b0, smp.sample_time} > warm_end);
        end
        return r;
    endfunction

    function automatic void add_cfg(input logic [bbfra_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bbfra_pkg::CFG_DATA_W-1:0] val);
        t_row row;
        row      = '{kind: ROW_CFG, idx: idx, val: val, smp: '0, want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [bbfra_pkg::TIME_W-1:0] t,
                                       input logic [bbfra_pkg::AMOUNT_W-1:0] amt);
        t_row row;
        row = '{kind: ROW_SAMPLE, idx: '0, val: '0, smp: '{t, amt}, want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [bbfra_pkg::TIME_W-1:0] t,
                                        input logic [bbfra_pkg::AMOUNT_W-1:0] amt,
                                        input logic [bbfra_pkg::TIME_W-1:0] age,
                                        input logic valid, input logic ovf);
        t_row row;
        row = '{kind: ROW_CHECKED, idx: '0, val: '0, smp: '{t, amt},
                want: '{age, valid, ovf}};
        directed_rows.push_back(row);
    endfunction

    // Hold the sender until every expected result has come back
    task automatic hold_until_drained();
        i_valid = 1'b0;
        while (age_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [bbfra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbfra_pkg::CFG_DATA_W-1:0] val);
        hold_until_drained();
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            bbfra_pkg::CFG_CAPACITY:   cap_mb  = val[bbfra_pkg::AMOUNT_W-1:0];
            bbfra_pkg::CFG_START_TIME: start_s = val;
            bbfra_pkg::CFG_WARM_UP:    warm_s  = val;
            default: ;
        endcase
    endtask

    // Offer one sample and record its expected result on transfer
    task automatic send_sample(input bbfra_pkg::t_in smp, input bit typed,
                               input bbfra_pkg::t_out want);
        bbfra_pkg::t_out pred;
        if (bursts_on && $urandom_range(0, 9) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = smp;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pred = predict_age(smp);
        age_expected.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Mostly advancing time with random amounts, some arbitrary timestamps
    task automatic run_random(input int count, input int amt_max, input int full_pct,
                              input int noise_pct, input int step_max);
        bbfra_pkg::t_in smp;
        int  k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                smp.sample_time = $urandom;
            end else begin
                now_s           = now_s + $urandom_range(0, step_max);
                smp.sample_time = now_s;
            end
            if ($urandom_range(0, 99) < full_pct)
                smp.sample_amount = $urandom_range(0, 24'hFFFFFF);
            else if ($urandom_range(0, 19) == 0)
                smp.sample_amount = '0;
            else
                smp.sample_amount = $urandom_range(0, amt_max);
            send_sample(smp, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [bbfra_pkg::TIME_W-1:0] exp,
                                        input logic [bbfra_pkg::TIME_W-1:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
            errors++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_result
        bbfra_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (age_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, o_data);
                errors++;
            end else begin
                want = age_expected.pop_front();
                check_field("oldest_age", want.oldest_age, o_data.oldest_age);
                check_field("age_valid", want.age_valid, o_data.age_valid);
                check_field("store_overflow", want.store_overflow, o_data.store_overflow);
            end
        end
    end

    // Stall the result side in random bursts
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0)
                stall_left--;
            else if (bursts_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
            i_stall = (stall_left != 0);
        end
    end

    // Stimulus
    initial begin : stimulus
        int waited;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        errors       = 0;
        bursts_on    = 1'b0;
        now_s        = '0;
        head_slot    = 0;
        tail_slot    = 0;
        kept_entries = 0;
        kept_total   = 0;
        cap_mb       = bbfra_pkg::CAPACITY_RESET;
        start_s      = bbfra_pkg::START_TIME_RESET;
        warm_s       = bbfra_pkg::WARM_UP_RESET;
        foreach (kept_time[k]) begin
            kept_time[k] = '0;
            kept_mb[k]   = '0;
        end

        // Directed rows: reset defaults, wrap, capacity extremes, ignored index
        add_checked(32'd0, 24'd0, 32'd0, 1'b0, 1'b0);
        add_checked(32'd100, 24'd1000, 32'd0, 1'b0, 1'b0);
        add_checked(32'd86401, 24'd0, 32'd86301, 1'b1, 1'b0);
        add_checked(32'd90000, 24'd535000, 32'd0, 1'b1, 1'b0);
        add_sample(32'd0, 24'd1);
        add_sample(32'hFFFF_FFFF, 24'hFF_FFFF);
        add_cfg(bbfra_pkg::CFG_CAPACITY, 32'd0);
        add_checked(32'd200, 24'd5, 32'd0, 1'b0, 1'b0);
        add_checked(32'd300, 24'd0, 32'd0, 1'b0, 1'b0);
        add_cfg(bbfra_pkg::CFG_CAPACITY, 32'h00FF_FFFF);
        add_cfg(bbfra_pkg::CFG_START_TIME, 32'hFFFF_FFFF);
        add_cfg(bbfra_pkg::CFG_WARM_UP, 32'hFFFF_FFFF);
        add_checked(32'hFFFF_FFFF, 24'd1, 32'd0, 1'b0, 1'b0);
        add_checked(32'd5, 24'hFF_FFFE, 32'd6, 1'b0, 1'b0);
        add_cfg(bbfra_pkg::CFG_START_TIME, 32'd0);
        add_cfg(bbfra_pkg::CFG_WARM_UP, 32'd0);
        add_checked(32'd1, 24'd0, 32'd2, 1'b1, 1'b0);
        add_checked(32'd0, 24'd0, 32'd1, 1'b0, 1'b0);
        add_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        add_sample(32'h5555_5555, 24'h55_5555);
        add_sample(32'hAAAA_AAAA, 24'hAA_AAAA);
        add_cfg(bbfra_pkg::CFG_CAPACITY, 32'd1);
        add_sample(32'hAAAA_AAAB, 24'd3);
        add_sample(32'hAAAA_AAAC, 24'd0);

        // Hold reset, then release
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            case (directed_rows[k].kind)
                ROW_CFG:     write_reg(directed_rows[k].idx, directed_rows[k].val);
                ROW_SAMPLE:  send_sample(directed_rows[k].smp, 1'b0, '0);
                ROW_CHECKED: send_sample(directed_rows[k].smp, 1'b1, directed_rows[k].want);
                default: ;
            endcase
        end

        // Default budget, warm-up crossing, several entries kept at a time
        write_reg(bbfra_pkg::CFG_CAPACITY, 32'(bbfra_pkg::CAPACITY_RESET));
        write_reg(bbfra_pkg::CFG_START_TIME, $urandom_range(0, 50000));
        write_reg(bbfra_pkg::CFG_WARM_UP, bbfra_pkg::WARM_UP_RESET);
        now_s     = '0;
        bursts_on = 1'b1;
        run_random(250, 150000, 3, 5, 1000);
        hold_until_drained();
        bursts_on = 1'b0;
        run_random(150, 150000, 3, 5, 1000);

        // Huge budget and tiny amounts: fill the store until it evicts
        write_reg(bbfra_pkg::CFG_CAPACITY, 32'h00FF_FFFF);
        write_reg(bbfra_pkg::CFG_START_TIME, $urandom_range(0, 20000));
        write_reg(bbfra_pkg::CFG_WARM_UP, 32'd0);
        now_s     = '0;
        bursts_on = 1'b1;
        run_random(1100, 15, 0, 2, 50);

        // Small budget, large and arbitrary samples
        write_reg(bbfra_pkg::CFG_CAPACITY, $urandom_range(1, 5000));
        write_reg(bbfra_pkg::CFG_START_TIME, $urandom);
        write_reg(bbfra_pkg::CFG_WARM_UP, $urandom_range(0, 100000));
        now_s = $urandom;
        run_random(200, 3000, 10, 15, 100000);
        bursts_on = 1'b0;
        run_random(100, 3000, 10, 15, 100000);

        // Drain, then watch for stray results
        i_valid = 1'b0;
        waited  = 0;
        while (age_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (age_expected.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, age_expected.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10ms;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: byte_budget_fifo_retention_age_core.f
design/bbfra_pkg.sv
design/bbfra_front.sv
design/bbfra_back.sv
design/byte_budget_fifo_retention_age_core.sv
sim/tb_byte_budget_fifo_retention_age_core.sv
